### rtl/assert_macros.svh
// Assertion helpers for the steering/brake sequencer RTL.
// GSB_ASSERT is clocked on clk_i and disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic form: explicit clock and active-low reset.
`define GSB_ASSERT_CLK(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error(msg);

// Block clock and reset.
`define GSB_ASSERT(label, prop, msg) \
  `GSB_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

### rtl/gsb_pkg.sv
// Types, codes and fixed-point constants of the ground steering/brake controller.
// No dependencies; used by the interfaces, controller, datapath and top level.
package gsb_pkg;

  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 15;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TARGET_HEADING = 1'b0,
    REG_TARGET_SPEED   = 1'b1
  } gsb_reg_e;

  typedef struct packed {
    logic [CfgIdxW-1:0]  reg_idx;
    logic [CfgDataW-1:0] wdata;
  } gsb_cfg_t;

  typedef struct packed {
    logic [15:0]        ground_speed;
    logic signed [15:0] yaw_angle;
    logic [15:0]        time_step;
  } gsb_in_t;

  typedef struct packed {
    logic signed [13:0] nose_wheel_cmd;
    logic signed [11:0] rudder_cmd;
    logic [12:0]        brake_cmd;
    logic               rudder_mode;
  } gsb_out_t;

  // Operand selection of the shared multiplier
  typedef enum logic [2:0] {
    MUL_SPEED = 3'd0,
    MUL_YAW   = 3'd1,
    MUL_LIMIT = 3'd2,
    MUL_ERR   = 3'd3,
    MUL_PI    = 3'd4
  } gsb_mul_sel_e;

  typedef struct packed {
    logic         load_in;
    logic         mul_en;
    gsb_mul_sel_e mul_sel;
    logic         ld_speed;
    logic         ld_err;
    logic         ld_limit;
    logic         ld_integ;
    logic         ld_out;
  } gsb_cmd_t;

  // m/s -> knots, x900/463, as ceil(2^26 * 900 / 463); exact floor for 16-bit speeds
  localparam int             SpeedShift = 26;
  localparam longint         SpeedMulL  = ((64'd900 << SpeedShift) + 64'd462) / 64'd463;
  localparam logic [26:0]    SpeedMul   = 27'(SpeedMulL);
  // rad/8192 -> deg/64 is x29335/65536
  localparam logic [15:0]    YawMul     = 16'd29335;
  localparam int             YawHalf    = 32768;
  // floor(x/10) = (x * 6554) >> 16 for x < 4096, and for the limit term
  localparam logic [15:0]    Recip10    = 16'd6554;

  localparam int HalfTurn     = 11520;
  localparam int FullTurn     = 23040;
  localparam int IntegLimit   = 3276800;
  localparam int IntegHalf    = 32;
  localparam int PiHalf       = 5120;
  localparam int SpeedRudder  = 7680;
  localparam int SpeedLow     = 2560;
  localparam int SpeedBand    = 1280;
  localparam int NwsLowLimit  = 4800;
  localparam int NwsBandStart = 1920;
  localparam int RudderLimit  = 1600;
  localparam int BrakeLimit   = 6400;

endpackage

### rtl/gsb_if.sv
// Valid/ready channel interfaces: configuration writes, input ticks, results.
// Depends on gsb_pkg for the payload structs.
interface gsb_cfg_if;
  import gsb_pkg::*;
  logic     valid;
  logic     ready;
  gsb_cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface gsb_in_if;
  import gsb_pkg::*;
  logic    valid;
  logic    ready;
  gsb_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface gsb_out_if;
  import gsb_pkg::*;
  logic     valid;
  logic     ready;
  gsb_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/gsb_ctrl.sv
// Sequencer of the steering/brake controller: steps the datapath per tick.
// Depends on gsb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module gsb_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output gsb_pkg::gsb_cmd_t cmd_o
);
  import gsb_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SPD  = 3'd1;
  localparam logic [2:0] S_YAW  = 3'd2;
  localparam logic [2:0] S_ERR  = 3'd3;
  localparam logic [2:0] S_MULE = 3'd4;
  localparam logic [2:0] S_ACC  = 3'd5;
  localparam logic [2:0] S_PI   = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o         = '0;
    cmd_o.mul_sel = MUL_SPEED;
    state_d       = state_q;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.load_in = in_valid_i;
        if (in_valid_i) state_d = S_SPD;
      end
      S_SPD: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_SPEED;
        state_d       = S_YAW;
      end
      S_YAW: begin
        cmd_o.ld_speed = 1'b1;
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_sel  = MUL_YAW;
        state_d        = S_ERR;
      end
      S_ERR: begin
        cmd_o.ld_err  = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_LIMIT;
        state_d       = S_MULE;
      end
      S_MULE: begin
        cmd_o.ld_limit = 1'b1;
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_sel  = MUL_ERR;
        state_d        = S_ACC;
      end
      S_ACC: begin
        cmd_o.ld_integ = 1'b1;
        state_d        = S_PI;
      end
      S_PI: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_PI;
        state_d       = S_OUT;
      end
      S_OUT: begin
        // wait here while the previous result is still unclaimed
        cmd_o.ld_out = slot_free;
        if (slot_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.ld_out) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  `GSB_ASSERT(a_accept_starts, (in_valid_i && in_ready_o) |=> (state_q == S_SPD), "tick transfer did not start sequence")
  `GSB_ASSERT(a_out_slot_free, cmd_o.ld_out |-> (!out_valid_q || out_ready_i), "result overwrote an unclaimed one")
  `GSB_ASSERT(a_out_loaded, cmd_o.ld_out |=> out_valid_q, "loaded result not offered")

endmodule

### rtl/gsb_datapath.sv
// Datapath of the steering/brake controller: config registers, shared
// multiplier, integrator and result register. Depends on gsb_pkg.
module gsb_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  gsb_pkg::gsb_cfg_t cfg_i,
  input  gsb_pkg::gsb_in_t  in_data_i,
  input  gsb_pkg::gsb_cmd_t cmd_i,
  output gsb_pkg::gsb_out_t res_o
);
  import gsb_pkg::*;

  logic signed [14:0] th_q;
  logic [14:0]        ts_q;
  gsb_in_t            in_q;
  logic [42:0]        prod_q;
  logic [16:0]        s_q;
  logic signed [14:0] e_q, e_d;
  logic [12:0]        lim_q, lim_d;
  logic signed [22:0] hi_q, hi_d;
  gsb_out_t           res_q, res_d;

  // multiplier operands
  logic [26:0]        mul_a;
  logic [15:0]        mul_b;
  logic signed [16:0] yaw_ext;
  logic [16:0]        yaw_abs;
  logic [16:0]        s_off;
  logic [18:0]        lim_arg;
  logic signed [15:0] e_w;
  logic [13:0]        e_abs;
  logic signed [23:0] hi_w;
  logic [21:0]        hi_abs;
  logic [22:0]        pi_sum;
  logic [12:0]        pi_arg;

  assign yaw_ext = 17'(in_q.yaw_angle);
  assign yaw_abs = 17'(yaw_ext[16] ? -yaw_ext : yaw_ext);
  assign s_off   = s_q - 17'(SpeedLow);
  assign lim_arg = (s_q < 17'(SpeedLow)) ? '0 : ({2'b0, s_off} << 1) + {2'b0, s_off};
  assign e_w     = 16'(e_q);
  assign e_abs   = 14'(e_w[15] ? -e_w : e_w);
  assign hi_w    = 24'(hi_q);
  assign hi_abs  = 22'(hi_w[23] ? -hi_w : hi_w);
  assign pi_sum  = {1'b0, hi_abs} + 23'(PiHalf);
  assign pi_arg  = pi_sum[22:10];

  always_comb begin
    case (cmd_i.mul_sel)
      MUL_SPEED: begin mul_a = SpeedMul;       mul_b = in_q.ground_speed; end
      MUL_YAW:   begin mul_a = 27'(yaw_abs);   mul_b = YawMul;            end
      MUL_LIMIT: begin mul_a = 27'(lim_arg);   mul_b = Recip10;           end
      MUL_ERR:   begin mul_a = 27'(e_abs);     mul_b = in_q.time_step;    end
      MUL_PI:    begin mul_a = 27'(pi_arg);    mul_b = Recip10;           end
      default:   begin mul_a = '0;             mul_b = '0;                end
    endcase
  end

  // heading error: rounded yaw, then one wrap step into [-180, 180)
  logic [29:0]        yaw_rnd;
  logic [13:0]        y_mag;
  logic signed [14:0] y_s;
  logic signed [16:0] herr;

  assign yaw_rnd = prod_q[29:0] + 30'(YawHalf);
  assign y_mag   = yaw_rnd[29:16];
  assign y_s     = in_q.yaw_angle[15] ? -$signed({1'b0, y_mag}) : $signed({1'b0, y_mag});
  assign herr    = 17'(th_q) - 17'(y_s);

  always_comb begin
    if (herr >= HalfTurn)      e_d = 15'(herr - FullTurn);
    else if (herr < -HalfTurn) e_d = 15'(herr + FullTurn);
    else                       e_d = 15'(herr);
  end

  // nose-wheel limit, 4800 below 10 kt, else 1920 - 0.3*(s - 2560)
  assign lim_d = (s_q < 17'(SpeedLow)) ? 13'(NwsLowLimit)
                                       : 13'(NwsBandStart) - prod_q[28:16];

  // integrator step with saturation
  logic [29:0]        inc_rnd;
  logic [23:0]        inc;
  logic signed [24:0] inc_s;
  logic signed [24:0] hi_sum;

  assign inc_rnd = prod_q[29:0] + 30'(IntegHalf);
  assign inc     = inc_rnd[29:6];
  assign inc_s   = e_q[14] ? -$signed({1'b0, inc}) : $signed({1'b0, inc});
  assign hi_sum  = 25'(hi_q) + inc_s;

  always_comb begin
    if (hi_sum > IntegLimit)       hi_d = 23'(IntegLimit);
    else if (hi_sum < -IntegLimit) hi_d = 23'(-IntegLimit);
    else                           hi_d = 23'(hi_sum);
  end

  // result: PI sum, steering, brake
  logic [8:0]         pi_q;
  logic signed [15:0] u;
  logic signed [15:0] pi_s;
  logic [13:0]        u_abs;
  logic [15:0]        m3;
  logic [16:0]        n_rnd;
  logic [15:0]        n_mag;
  logic [12:0]        nws_mag;
  logic [14:0]        r_rnd;
  logic [13:0]        r_mag;
  logic [10:0]        rud_mag;
  logic               rudder;
  logic signed [17:0] dspd;
  logic [17:0]        b_rnd;
  logic [16:0]        b_half;

  assign pi_q    = prod_q[24:16];
  assign pi_s    = hi_q[22] ? -$signed({7'b0, pi_q}) : $signed({7'b0, pi_q});
  assign u       = 16'(e_q) + pi_s;
  assign u_abs   = 14'(u[15] ? -u : u);
  assign m3      = ({2'b0, u_abs} << 1) + {2'b0, u_abs};
  assign n_rnd   = {1'b0, m3} + 17'd1;
  assign n_mag   = n_rnd[16:1];
  assign nws_mag = (n_mag > {3'b0, lim_q}) ? lim_q : 13'(n_mag);
  assign r_rnd   = {1'b0, u_abs} + 15'd1;
  assign r_mag   = r_rnd[14:1];
  assign rud_mag = (r_mag > 14'(RudderLimit)) ? 11'(RudderLimit) : 11'(r_mag);
  assign rudder  = (s_q >= 17'(SpeedRudder));
  assign dspd    = $signed({1'b0, s_q}) - $signed({3'b0, ts_q});
  assign b_rnd   = 18'(dspd) + 18'd1;
  assign b_half  = b_rnd[17:1];

  always_comb begin
    res_d.rudder_mode    = rudder;
    res_d.nose_wheel_cmd = '0;
    res_d.rudder_cmd     = '0;
    if (rudder) begin
      res_d.rudder_cmd = u[15] ? -$signed({1'b0, rud_mag}) : $signed({1'b0, rud_mag});
    end else begin
      res_d.nose_wheel_cmd = u[15] ? -$signed({1'b0, nws_mag}) : $signed({1'b0, nws_mag});
    end
    if (dspd > SpeedBand) begin
      res_d.brake_cmd = (b_half > 17'(BrakeLimit)) ? 13'(BrakeLimit) : 13'(b_half);
    end else begin
      res_d.brake_cmd = '0;
    end
  end

  // control state: config registers and integrator
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      th_q <= '0;
      ts_q <= '0;
      hi_q <= '0;
    end else begin
      if (cfg_we_i) begin
        if (gsb_reg_e'(cfg_i.reg_idx) == REG_TARGET_HEADING) th_q <= $signed(cfg_i.wdata);
        else ts_q <= cfg_i.wdata;
      end
      if (cmd_i.ld_integ) hi_q <= hi_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in)  in_q   <= in_data_i;
    if (cmd_i.mul_en)   prod_q <= 43'(mul_a) * 43'(mul_b);
    if (cmd_i.ld_speed) s_q    <= prod_q[42:SpeedShift];
    if (cmd_i.ld_err)   e_q    <= e_d;
    if (cmd_i.ld_limit) lim_q  <= lim_d;
    if (cmd_i.ld_out)   res_q  <= res_d;
  end

  assign res_o = res_q;

endmodule

### rtl/ground_steering_brake_controller.sv
// Ground steering and brake controller, top level.
// Ticks are taken one at a time: the sequencer steps one shared 27x16 multiplier
// through 5 products, then loads the result into the output register.
// A finished result waits in an output register while the next tick is taken;
// a result still unclaimed when the next one is done holds the sequencer.
// Reset (async, active low) clears the integrator, both targets and all valid state.
module ground_steering_brake_controller (
  input  logic    clk_i,
  input  logic    rst_ni,
  gsb_cfg_if.sink  cfg_i,
  gsb_in_if.sink   in_i,
  gsb_out_if.source res_o
);
  import gsb_pkg::*;

  gsb_cmd_t cmd;
  logic     cfg_we;

  // Config writes are always taken; they land in the datapath registers.
  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid;

  // Sequencer: one tick at a time, steps the datapath through the
  // speed, yaw, error/limit, integrator, PI and output steps.
  gsb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .cmd_o       (cmd)
  );

  // Datapath: shared multiplier with registered product, integrator,
  // result register driving the output payload.
  gsb_datapath u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we),
    .cfg_i     (cfg_i.data),
    .in_data_i (in_i.data),
    .cmd_i     (cmd),
    .res_o     (res_o.data)
  );

endmodule

### tb/tb_top.sv
// Self-checking bench for ground_steering_brake_controller: drives ticks and target-register
// writes, predicts steering, rudder and brake commands in SystemVerilog and checks each result.
// Needs gsb_pkg, the gsb_*_if interfaces and the controller RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import gsb_pkg::*;

  localparam int NumSettings  = 7;
  localparam int RandPerPhase = 260;
  localparam int MaxReports   = 10;
  localparam int DrainCycles  = 20;

  logic clk_i;
  logic rst_ni;

  gsb_cfg_if cfg_if ();
  gsb_in_if  tick_if ();
  gsb_out_if res_if ();

  ground_steering_brake_controller dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (tick_if),
    .res_o  (res_if)
  );

  always #5 clk_i = ~clk_i;

  // Predictor state: targets as written, integrator in 1/65536 degree-second
  longint   heading_tgt_q6;
  longint   speed_tgt_q8;
  longint   heading_integ;

  gsb_in_t  tick_q[$];     // ticks waiting for the driver
  gsb_out_t cmd_exp_q[$];  // predicted commands, oldest first

  bit steady;              // no idling on either side while set
  int mismatch_cnt;
  int tick_cnt;
  int checked_cnt;
  int queued_cnt;          // ticks handed to the driver so far
  int rudder_cnt;
  int brake_cnt;
  int clamp_cnt;

  // Divide, rounding half away from zero
  function automatic longint rnd_div(longint n, longint d);
    if (n >= 0) return (n + d / 2) / d;
    return -((-n + d / 2) / d);
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // One control tick: updates the integrator and returns the command set
  function automatic gsb_out_t predict_cmd(gsb_in_t t);
    longint   spd, yaw_q6, err, pi, lim, nws, rud, brk, over;
    bit       rud_mode;
    gsb_out_t r;
    spd    = longint'(t.ground_speed) * 900 / 463;
    yaw_q6 = rnd_div(longint'($signed(t.yaw_angle)) * 29335, 65536);
    // heading error wrapped into [-180, 180) degrees
    err    = heading_tgt_q6 - yaw_q6 + HalfTurn + 3 * FullTurn;
    err    = (err % FullTurn) - HalfTurn;
    heading_integ = clip(heading_integ + rnd_div(err * longint'(t.time_step), 64),
                         -IntegLimit, IntegLimit);
    pi     = err + rnd_div(heading_integ, 10240);
    nws    = 0;
    rud    = 0;
    brk    = 0;
    rud_mode = (spd >= SpeedRudder);
    if (!rud_mode) begin
      // limit steps from 75 deg down to 30 deg at 10 kt, then falls to 6 deg at 30 kt
      if (spd < SpeedLow) lim = NwsLowLimit;
      else lim = NwsBandStart - ((spd - SpeedLow) * 3) / 10;
      nws = rnd_div(3 * pi, 2);
      if (nws > lim || nws < -lim) clamp_cnt++;
      nws = clip(nws, -lim, lim);
    end else begin
      rud = rnd_div(pi, 2);
      if (rud > RudderLimit || rud < -RudderLimit) clamp_cnt++;
      rud = clip(rud, -RudderLimit, RudderLimit);
      rudder_cnt++;
    end
    // brake only on overspeed beyond the 5 kt band
    over = spd - speed_tgt_q8;
    if (over > SpeedBand) begin
      brk = clip(rnd_div(over, 2), 0, BrakeLimit);
      brake_cnt++;
    end
    r.nose_wheel_cmd = 14'(nws);
    r.rudder_cmd     = 12'(rud);
    r.brake_cmd      = 13'(brk);
    r.rudder_mode    = rud_mode;
    return r;
  endfunction

  // Tick driver: takes the next tick from the queue, idles at random unless steady.
  // The prediction is made at the transfer edge so it sees the integrator in order.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (tick_if.valid && tick_if.ready) begin
        cmd_exp_q.push_back(predict_cmd(tick_if.data));
        tick_cnt++;
      end
      if (!tick_if.valid || tick_if.ready) begin
        if (tick_q.size() != 0 && (steady || $urandom_range(99) >= 36)) begin
          tick_if.valid <= 1'b1;
          tick_if.data  <= tick_q.pop_front();
        end else begin
          tick_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each transfer against the oldest prediction,
  // and stalls the result channel at random unless steady.
  always @(posedge clk_i) begin
    gsb_out_t want;
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        if (cmd_exp_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MaxReports)
            $display("[%0t] unexpected result: nws %0d rud %0d brake %0d mode %0d", $realtime,
                     res_if.data.nose_wheel_cmd, res_if.data.rudder_cmd,
                     res_if.data.brake_cmd, res_if.data.rudder_mode);
        end else begin
          want = cmd_exp_q.pop_front();
          checked_cnt++;
          if (res_if.data.nose_wheel_cmd !== want.nose_wheel_cmd ||
              res_if.data.rudder_cmd     !== want.rudder_cmd ||
              res_if.data.brake_cmd      !== want.brake_cmd ||
              res_if.data.rudder_mode    !== want.rudder_mode) begin
            mismatch_cnt++;
            if (mismatch_cnt <= MaxReports)
              $display("[%0t] result %0d: nws %0d/%0d rud %0d/%0d brake %0d/%0d mode %0d/%0d",
                       $realtime, checked_cnt,
                       res_if.data.nose_wheel_cmd, want.nose_wheel_cmd,
                       res_if.data.rudder_cmd, want.rudder_cmd,
                       res_if.data.brake_cmd, want.brake_cmd,
                       res_if.data.rudder_mode, want.rudder_mode);
          end
        end
      end
      res_if.ready <= steady || ($urandom_range(99) >= 36);
    end
  end

  // Register write; the predictor takes the new target at the transfer edge
  task automatic write_reg(gsb_reg_e idx, logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_if.valid        <= 1'b1;
    cfg_if.data.reg_idx <= idx;
    cfg_if.data.wdata   <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      REG_TARGET_HEADING: heading_tgt_q6 = longint'($signed(val));
      REG_TARGET_SPEED:   speed_tgt_q8   = longint'(val);
      default: ;
    endcase
  endtask

  // Main sequence: reset, then one phase per target setting. Each phase is
  // drained completely before the targets change, so writes land on an idle block.
  initial begin
    int       hdg_set [NumSettings];
    int       spd_set [NumSettings];
    gsb_in_t  tk;
    longint   yaw_l;
    int       p, i;
    hdg_set = '{0, -16384, 16383, -11520, 11519, 0, 0};
    spd_set = '{0, 32767, 0, 7680, 2560, 0, 1000};
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    cfg_if.valid   = 1'b0;
    cfg_if.data    = '0;
    tick_if.valid  = 1'b0;
    tick_if.data   = '0;
    res_if.ready   = 1'b0;
    steady         = 1'b0;
    heading_tgt_q6 = 0;
    speed_tgt_q8   = 0;
    heading_integ  = 0;
    mismatch_cnt   = 0;
    tick_cnt       = 0;
    checked_cnt    = 0;
    queued_cnt     = 0;
    rudder_cnt     = 0;
    brake_cnt      = 0;
    clamp_cnt      = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (p = 0; p < NumSettings; p++) begin
      if (p > 0) begin
        if (p == 5) begin
          hdg_set[p] = int'($signed(15'($urandom)));
          spd_set[p] = $urandom_range(32767);
        end
        write_reg(REG_TARGET_HEADING, 15'(hdg_set[p]));
        write_reg(REG_TARGET_SPEED, 15'(spd_set[p]));
      end
      steady = (p == 2);  // the long stretch without idling

      if (p == 0) begin
        // speed, yaw and time-step extremes, mode and limit-band edges
        tick_q.push_back('{16'd0,     16'sd0,      16'd0});      // zero time step
        tick_q.push_back('{16'd65535, 16'sd25736,  16'd65535});
        tick_q.push_back('{16'd65535, -16'sd25736, 16'd65535});
        tick_q.push_back('{16'd1316,  16'sd32767,  16'd1});      // yaw beyond range
        tick_q.push_back('{16'd1317,  -16'sd32768, 16'd1});
        tick_q.push_back('{16'd3950,  16'sd1000,   16'd6554});   // last nose-wheel speed
        tick_q.push_back('{16'd3951,  -16'sd1000,  16'd6554});   // first rudder speed
        tick_q.push_back('{16'd2000,  16'sd12000,  16'd0});
        tick_q.push_back('{16'd700,   -16'sd12000, 16'd65535});
        tick_q.push_back('{16'd660,   16'sd50,     16'd300});    // just beyond brake band
        tick_q.push_back('{16'd661,   -16'sd50,    16'd300});
        tick_q.push_back('{16'd2634,  16'sd0,      16'd0});      // mid limit band
        tick_q.push_back('{16'd3400,  16'sd25736,  16'd32768});
        tick_q.push_back('{16'd20000, -16'sd3000,  16'd1000});
        tick_q.push_back('{16'd3300,  16'sd40,     16'd100});    // braking, below the brake limit
        tick_q.push_back('{16'd500,   -16'sd20,    16'd65535});
        tick_q.push_back('{16'd100,   16'sd0,      16'd65535});
        tick_q.push_back('{16'd65535, 16'sd0,      16'd0});
      end

      for (i = 0; i < RandPerPhase; i++) begin
        // speed spread over the nose-wheel, band and rudder regions
        case ($urandom_range(3))
          0:       tk.ground_speed = 16'($urandom_range(0, 1400));
          1:       tk.ground_speed = 16'($urandom_range(1200, 4100));
          2:       tk.ground_speed = 16'($urandom_range(3800, 8000));
          default: tk.ground_speed = 16'($urandom);
        endcase
        // yaw: mostly in range, some near the target so the PI term stays linear
        case ($urandom_range(7)) inside
          0:       tk.yaw_angle = 16'($urandom);
          1, 2: begin
            yaw_l = heading_tgt_q6 * 65536 / 29335 + longint'($urandom_range(0, 400)) - 200;
            tk.yaw_angle = 16'(yaw_l);
          end
          default: tk.yaw_angle = 16'(longint'($urandom_range(0, 51472)) - 25736);
        endcase
        case ($urandom_range(15)) inside
          0:          tk.time_step = 16'd0;
          1, 2, 3, 4: tk.time_step = 16'($urandom_range(1, 256));
          5, 6:       tk.time_step = 16'($urandom);
          default:    tk.time_step = 16'($urandom_range(256, 8192));
        endcase
        tick_q.push_back(tk);
      end
      // the driver cannot pop before this block waits, so the queue holds this phase
      queued_cnt += tick_q.size();

      // hold off until every queued tick has come back as a checked result
      while (checked_cnt < queued_cnt) @(posedge clk_i);
      repeat (10) @(posedge clk_i);
    end

    steady = 1'b0;
    repeat (DrainCycles) @(posedge clk_i);
    $display("Covered %0d ticks over %0d target settings: %0d rudder-mode, %0d braking,",
             tick_cnt, NumSettings, rudder_cnt, brake_cnt);
    $display("%0d saturated steering commands; %0d results checked, %0d mismatches.",
             clamp_cnt, checked_cnt, mismatch_cnt);
    if (mismatch_cnt == 0 && cmd_exp_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog, far above the slowest legal run
  initial begin
    #5_000_000;
    $display("Timeout with %0d results outstanding", cmd_exp_q.size());
    $display("Some tests failed");
    $finish;
  end

endmodule

### ground_steering_brake_controller.f
+incdir+rtl
rtl/gsb_pkg.sv
rtl/gsb_if.sv
rtl/gsb_ctrl.sv
rtl/gsb_datapath.sv
rtl/ground_steering_brake_controller.sv
tb/tb_top.sv
